// File: rtl/core/lsh_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening block.
package lsh_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CFG_W         = 12;
    localparam int PIX_W         = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam int                 RECIP_SHIFT = 11;
    localparam logic [9:0]         RECIP_3     = 10'd683;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eor;
        logic             eof;
    } out_item_t;

endpackage

// File: rtl/core/lsh_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle.
module lsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/laplacian_sharpen_3x3.sv
// Streaming 3x3 Laplacian sharpening of an 8-bit grayscale frame.
// The block takes one pixel per clock in raster order while not stalled and gives one sharpened
// pixel for every interior pixel through the window stage register and the output queue. Rate
// is set by the two line-store RAMs, each doing one read and one write per clock; a two-entry
// output queue lets input keep flowing while a result waits. Border pixels give no result. Line
// stores are not cleared after reset; entries are read only after the current frame wrote them.
module laplacian_sharpen_3x3 import lsh_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] pixel_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] sharpened_pixel,
    output logic             end_of_row,
    output logic             end_of_frame,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [CFG_W-1:0] row_reg;
    logic [CFG_W-1:0] row_next;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_eor_reg;
    logic             s1_eof_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [AW-1:0]    s1_idx_reg;

    logic [PIX_W-1:0] tap_reg [6];

    out_item_t        fifo_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    logic             accept;
    logic             push;
    logic             pop;
    logic [CMP_W-1:0] eff_w;
    logic [CFG_W:0]   eff_h;
    logic             last_col;
    logic             last_row;
    logic             emit;
    logic [2:0]       occ;

    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [10:0]      ring_sum;
    logic [10:0]      centre_x8;
    logic signed [11:0] lap;
    logic             lap_neg;
    logic [10:0]      lap_mag;
    logic [20:0]      prod;
    logic [9:0]       quo;
    logic signed [11:0] quo_s;
    logic signed [11:0] val;
    out_item_t        item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < MIN_DIM)
        begin
            eff_w = CMP_W'(MIN_DIM);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            eff_w = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CMP_W'(width_reg);
        end
        eff_h = (height_reg < MIN_DIM) ? {1'b0, MIN_DIM} : {1'b0, height_reg};
    end

    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= eff_w;
    assign last_row = ({1'b0, row_reg} + 13'd1) >= eff_h;
    assign emit     = (row_reg >= CFG_W'(2)) && (col_reg >= AW'(2));

    assign pop    = (count_reg != 2'd0) && !out_stall;
    assign push   = s1_valid_reg && s1_emit_reg;
    assign occ    = {1'b0, count_reg} + {2'b00, push};
    assign in_stall = occ > ({2'b00, pop} + 3'd1);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + CFG_W'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg  <= emit;
            s1_eor_reg   <= last_col;
            s1_eof_reg   <= last_col && last_row;
            s1_pixel_reg <= pixel_in;
            s1_idx_reg   <= col_reg;
        end
    end

    lsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (s1_pixel_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid)
    );

    lsh_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_idx_reg),
        .wdata (mid),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            tap_reg[0] <= tap_reg[3];
            tap_reg[1] <= tap_reg[4];
            tap_reg[2] <= tap_reg[5];
            tap_reg[3] <= top;
            tap_reg[4] <= mid;
            tap_reg[5] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        ring_sum  = 11'(tap_reg[0]) + 11'(tap_reg[1]) + 11'(tap_reg[2]) + 11'(tap_reg[3])
                  + 11'(tap_reg[5]) + 11'(top) + 11'(mid) + 11'(s1_pixel_reg);
        centre_x8 = {tap_reg[4], 3'b000};
        lap       = $signed({1'b0, centre_x8}) - $signed({1'b0, ring_sum});
        lap_neg   = lap[11];
        lap_mag   = lap_neg ? 11'(-lap) : 11'(lap);
        prod      = 21'(lap_mag) * 21'(RECIP_3);
        quo       = prod[RECIP_SHIFT +: 10];
        quo_s     = lap_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        val       = $signed({4'b0000, tap_reg[4]}) + quo_s;
        if (val < 0)
        begin
            item.pixel = '0;
        end
        else if (val > $signed({4'b0000, PIX_MAX}))
        begin
            item.pixel = PIX_MAX;
        end
        else
        begin
            item.pixel = val[PIX_W-1:0];
        end
        item.eor = s1_eor_reg;
        item.eof = s1_eof_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

    assign out_valid       = count_reg != 2'd0;
    assign sharpened_pixel = fifo_reg[rd_ptr_reg].pixel;
    assign end_of_row      = fifo_reg[rd_ptr_reg].eor;
    assign end_of_frame    = fifo_reg[rd_ptr_reg].eof;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && count_reg == 2'd2 |-> pop)
        else $error("result pushed into full output queue");

    a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach window stage");

    a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_row)
        else $error("end of frame without end of row");

endmodule

// File: dv/laplacian_sharpen_3x3_tb.sv
// Self-checking testbench for laplacian_sharpen_3x3.
`timescale 1ns / 1ps

module laplacian_sharpen_3x3_tb;
    import lsh_pkg::*;

    localparam int DRAIN_SLACK = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic [PIX_W-1:0] pixel_in      = '0;
    logic             out_valid;
    logic             out_stall     = 1'b0;
    logic [PIX_W-1:0] sharpened_pixel;
    logic             end_of_row;
    logic             end_of_frame;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    cfg_index_t       cfg_index     = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data      = '0;

    int          src_idle_pct  = 22;
    int          sink_idle_pct = 88;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    int          mismatches    = 0;
    int unsigned pixels_sent   = 0;

    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    logic [PIX_W-1:0] prev_row  [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0] prev_row2 [MAX_WIDTH_DEF] = '{default: '0};
    logic [PIX_W-1:0] taps      [6]             = '{default: '0};
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    out_item_t        expected_pixels [$];

    laplacian_sharpen_3x3 dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_in        (pixel_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .sharpened_pixel (sharpened_pixel),
        .end_of_row      (end_of_row),
        .end_of_frame    (end_of_frame),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void predict_sharpened(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      idx;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic             last_col;
        logic             last_row;
        int               centre;
        int               ring;
        int               lap;
        int               val;
        out_item_t        item;
        w = width_reg;
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        h = height_reg;
        if (h < 3)
            h = 3;
        idx      = col_pos % MAX_WIDTH_DEF;
        top      = prev_row2[idx];
        mid      = prev_row[idx];
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        if (row_pos >= 2 && col_pos >= 2)
        begin
            centre = int'(taps[4]);
            ring   = int'(taps[0]) + int'(taps[1]) + int'(taps[2]) + int'(taps[3])
                   + int'(taps[5]) + int'(top) + int'(mid) + int'(px);
            lap    = 8 * centre - ring;
            val    = centre + lap / 3;
            if (val > 255)
                val = 255;
            if (val < 0)
                val = 0;
            item.pixel = val[PIX_W-1:0];
            item.eor   = last_col;
            item.eof   = last_col && last_row;
            expected_pixels.push_back(item);
        end
        taps[0] = taps[3];
        taps[1] = taps[4];
        taps[2] = taps[5];
        taps[3] = top;
        taps[4] = mid;
        taps[5] = px;
        prev_row2[idx] = mid;
        prev_row[idx]  = px;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
        end
        else
            col_pos = (col_pos + 1) & 11'h7FF;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sharpened(px);
        pixels_sent++;
    endtask

    task automatic flush_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        flush_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic finish_frame();
        send_pixel(random_pixel());
        while (col_pos != 0 || row_pos != 0)
            send_pixel(random_pixel());
    endtask

    task automatic send_window(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] ring,
                               input logic [PIX_W-1:0] corner);
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4 ? centre : (i == 0 ? corner : ring));
    endtask

    // shrink both dimensions mid-frame while the column is past the new last column
    task automatic test_reset_dimensions();
        repeat (WIDTH_RESET + 11) send_pixel(random_pixel());
        write_reg(CFG_IMAGE_WIDTH, 12'd8);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        finish_frame();
    endtask

    task automatic test_pixel_extremes();
        write_reg(CFG_IMAGE_WIDTH, 12'd0);
        write_reg(CFG_IMAGE_HEIGHT, 12'd0);
        send_window(PIX_MAX, 8'd0, 8'd0);
        write_reg(CFG_IMAGE_WIDTH, 12'd1);
        write_reg(CFG_IMAGE_HEIGHT, 12'd1);
        send_window(8'd0, PIX_MAX, PIX_MAX);
        // negative sum that truncates toward zero
        write_reg(CFG_IMAGE_WIDTH, 12'd2);
        write_reg(CFG_IMAGE_HEIGHT, 12'd2);
        send_window(8'd1, 8'd0, 8'd10);
    endtask

    // run part of a row at the largest width setting, then shrink the width to close it
    task automatic test_widest_frame();
        write_reg(CFG_IMAGE_WIDTH, 12'hFFF);
        write_reg(CFG_IMAGE_HEIGHT, 12'd3);
        repeat (100) send_pixel(random_pixel());
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        finish_frame();
    endtask

    task automatic test_tallest_frame();
        write_reg(CFG_IMAGE_WIDTH, 12'd3);
        write_reg(CFG_IMAGE_HEIGHT, 12'hFFF);
        repeat (90) send_pixel(random_pixel());
        write_reg(CFG_IMAGE_HEIGHT, 12'd2);
        finish_frame();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_IMAGE_WIDTH, 12'd16);
        write_reg(CFG_IMAGE_HEIGHT, 12'd8);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        finish_frame();
        flush_results();
    endtask

    task automatic test_random_frames(input int src_pct, input int sink_pct, input int n_pixels);
        int unsigned      stop_at;
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      split;
        logic [CFG_W-1:0] w_cfg;
        logic [CFG_W-1:0] h_cfg;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = pixels_sent + n_pixels;
        while (pixels_sent < stop_at)
        begin
            w_cfg = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                                : CFG_W'($urandom_range(3, 24));
            h_cfg = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                                : CFG_W'($urandom_range(3, 10));
            write_reg(CFG_IMAGE_WIDTH, w_cfg);
            write_reg(CFG_IMAGE_HEIGHT, h_cfg);
            w_eff = (w_cfg < 3) ? 3 : w_cfg;
            h_eff = (h_cfg < 3) ? 3 : h_cfg;
            // never grow the width mid-frame
            if ($urandom_range(0, 3) == 0)
            begin
                split = $urandom_range(1, w_eff * h_eff - 1);
                repeat (split) send_pixel(random_pixel());
                write_reg(CFG_IMAGE_WIDTH, CFG_W'($urandom_range(3, w_eff)));
                write_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, h_eff + 4)));
            end
            finish_frame();
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected transfer: sharpened_pixel %0d", sharpened_pixel);
                mismatches++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (sharpened_pixel !== want.pixel)
                begin
                    $error("sharpened_pixel: expected %0d, actual %0d", want.pixel,
                           sharpened_pixel);
                    mismatches++;
                end
                if (end_of_row !== want.eor)
                begin
                    $error("end_of_row: expected %0b, actual %0b", want.eor, end_of_row);
                    mismatches++;
                end
                if (end_of_frame !== want.eof)
                begin
                    $error("end_of_frame: expected %0b, actual %0b", want.eof, end_of_frame);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_dimensions();
        test_pixel_extremes();
        test_widest_frame();
        test_tallest_frame();
        test_output_backpressure();
        test_random_frames(22, 88, 250);
        test_random_frames(88, 22, 250);
        test_random_frames(0, 0, 250);
        flush_results();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
